// ----- rtl/core/enwp_pkg.sv -----
package enwp_pkg;

  localparam int MAX_WORD_CHARS = 32;
  localparam int NUM_WORDS      = 30;
  localparam int WORD_BYTES     = 13;

  localparam logic [3:0] HUNDRED_LEN = 4'd10;
  localparam logic [9:0] MAX_VALUE   = 10'd255;

  typedef enum logic [2:0] {
    KIND_UNIT,
    KIND_TEEN,
    KIND_TENS,
    KIND_ZERO,
    KIND_HUND
  } word_kind_t;

  typedef struct packed {
    logic [8*WORD_BYTES-1:0] text;
    logic [3:0]              len;
    logic [7:0]              value;
    word_kind_t              kind;
  } word_entry_t;

  // units, teens, tens, zero, hundred prefixes
  localparam logic [NUM_WORDS-1:0] UNIT_MASK  = 30'h0000_01FF;
  localparam logic [NUM_WORDS-1:0] BELOW_MASK = 30'h07FF_FFFF;
  localparam logic [NUM_WORDS-1:0] TOP_MASK   = 30'h3FFF_FFFF;

  function automatic word_entry_t mk_entry(input logic [8*WORD_BYTES-1:0] text,
                                           input logic [3:0] len,
                                           input logic [7:0] value,
                                           input word_kind_t kind);
    word_entry_t e;
    e.text  = text;
    e.len   = len;
    e.value = value;
    e.kind  = kind;
    return e;
  endfunction

  // text is right aligned: first letter sits in the highest used byte
  function automatic word_entry_t word_entry(input logic [4:0] idx);
    word_entry_t e;
    e = '0;
    case (idx)
      5'd0:    e = mk_entry("ONE",           4'd3,  8'd1,   KIND_UNIT);
      5'd1:    e = mk_entry("TWO",           4'd3,  8'd2,   KIND_UNIT);
      5'd2:    e = mk_entry("THREE",         4'd5,  8'd3,   KIND_UNIT);
      5'd3:    e = mk_entry("FOUR",          4'd4,  8'd4,   KIND_UNIT);
      5'd4:    e = mk_entry("FIVE",          4'd4,  8'd5,   KIND_UNIT);
      5'd5:    e = mk_entry("SIX",           4'd3,  8'd6,   KIND_UNIT);
      5'd6:    e = mk_entry("SEVEN",         4'd5,  8'd7,   KIND_UNIT);
      5'd7:    e = mk_entry("EIGHT",         4'd5,  8'd8,   KIND_UNIT);
      5'd8:    e = mk_entry("NINE",          4'd4,  8'd9,   KIND_UNIT);
      5'd9:    e = mk_entry("TEN",           4'd3,  8'd10,  KIND_TEEN);
      5'd10:   e = mk_entry("ELEVEN",        4'd6,  8'd11,  KIND_TEEN);
      5'd11:   e = mk_entry("TWELVE",        4'd6,  8'd12,  KIND_TEEN);
      5'd12:   e = mk_entry("THIRTEEN",      4'd8,  8'd13,  KIND_TEEN);
      5'd13:   e = mk_entry("FOURTEEN",      4'd8,  8'd14,  KIND_TEEN);
      5'd14:   e = mk_entry("FIFTEEN",       4'd7,  8'd15,  KIND_TEEN);
      5'd15:   e = mk_entry("SIXTEEN",       4'd7,  8'd16,  KIND_TEEN);
      5'd16:   e = mk_entry("SEVENTEEN",     4'd9,  8'd17,  KIND_TEEN);
      5'd17:   e = mk_entry("EIGHTEEN",      4'd8,  8'd18,  KIND_TEEN);
      5'd18:   e = mk_entry("NINETEEN",      4'd8,  8'd19,  KIND_TEEN);
      5'd19:   e = mk_entry("TWENTY",        4'd6,  8'd20,  KIND_TENS);
      5'd20:   e = mk_entry("THIRTY",        4'd6,  8'd30,  KIND_TENS);
      5'd21:   e = mk_entry("FORTY",         4'd5,  8'd40,  KIND_TENS);
      5'd22:   e = mk_entry("FIFTY",         4'd5,  8'd50,  KIND_TENS);
      5'd23:   e = mk_entry("SIXTY",         4'd5,  8'd60,  KIND_TENS);
      5'd24:   e = mk_entry("SEVENTY",       4'd7,  8'd70,  KIND_TENS);
      5'd25:   e = mk_entry("EIGHTY",        4'd6,  8'd80,  KIND_TENS);
      5'd26:   e = mk_entry("NINETY",        4'd6,  8'd90,  KIND_TENS);
      5'd27:   e = mk_entry("ZERO",          4'd4,  8'd0,   KIND_ZERO);
      5'd28:   e = mk_entry("ONEHUNDREDAND", 4'd13, 8'd100, KIND_HUND);
      5'd29:   e = mk_entry("TWOHUNDREDAND", 4'd13, 8'd200, KIND_HUND);
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

// ----- rtl/core/english_numeral_word_parser_core.sv -----
// the result item of a word is registered and appears in the cycle after its last character is taken
// throughput: one character item per cycle; a last character waits only while
//   an earlier result is held in the output register under stall
// reset (synchronous, rst high): recognizer back to start of word, running
//   value and length count cleared, no result pending
module english_numeral_word_parser_core
  import enwp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] letter,
  input  logic       final_char,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] number_value,
  output logic       is_valid
);

  logic [NUM_WORDS-1:0] mask;
  logic [NUM_WORDS-1:0] mask_next;
  logic [3:0]           pos;
  logic [3:0]           pos_next;
  logic [8:0]           running_value;
  logic [8:0]           running_value_next;
  logic [5:0]           chars_seen;
  logic [5:0]           chars_seen_next;
  logic                 rejected;
  logic                 rejected_next;

  logic [NUM_WORDS-1:0] hit;
  logic                 tens_done;
  logic                 hund_done;
  logic [7:0]           step_value;
  logic                 fin_any;
  logic [7:0]           fin_value;
  logic                 reject_now;
  logic [9:0]           sum;
  logic                 word_ok;
  logic                 accept;
  logic                 take_final;

  assign char_stall = final_char & result_valid & result_stall;
  assign accept     = char_valid & ~char_stall;
  assign take_final = accept & final_char;

  // match the current letter against every live word
  always_comb begin
    word_entry_t e;
    logic [3:0]  idx;
    logic [7:0]  ch;
    hit        = '0;
    tens_done  = 1'b0;
    hund_done  = 1'b0;
    step_value = '0;
    fin_any    = 1'b0;
    fin_value  = '0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      e      = word_entry(5'(i));
      idx    = e.len - 4'd1 - pos;
      ch     = e.text[{idx, 3'b000} +: 8];
      hit[i] = mask[i] && (pos < e.len) && (ch == letter);
      if (hit[i] && (pos == e.len - 4'd1)) begin
        case (e.kind)
          KIND_TENS: begin
            tens_done  = 1'b1;
            step_value = step_value | e.value;
            fin_any    = 1'b1;
            fin_value  = fin_value | e.value;
          end
          KIND_HUND: begin
            hund_done  = 1'b1;
            step_value = step_value | e.value;
          end
          default: begin
            fin_any   = 1'b1;
            fin_value = fin_value | e.value;
          end
        endcase
      end
      if (hit[i] && (e.kind == KIND_HUND) && (pos == HUNDRED_LEN - 4'd1)) begin
        fin_any   = 1'b1;
        fin_value = fin_value | e.value;
      end
    end
  end

  assign reject_now = rejected | (chars_seen == 6'(MAX_WORD_CHARS));
  assign sum        = {1'b0, running_value} + {2'b00, fin_value};
  assign word_ok    = fin_any & ~reject_now & (sum <= MAX_VALUE);

  always_comb begin
    mask_next          = mask;
    pos_next           = pos;
    running_value_next = running_value;
    chars_seen_next    = chars_seen;
    rejected_next      = rejected;
    if (accept) begin
      if (final_char) begin
        mask_next          = TOP_MASK;
        pos_next           = '0;
        running_value_next = '0;
        chars_seen_next    = '0;
        rejected_next      = 1'b0;
      end else begin
        rejected_next = reject_now;
        if (!reject_now) begin
          chars_seen_next = chars_seen + 6'd1;
        end
        if (tens_done) begin
          mask_next          = UNIT_MASK;
          pos_next           = '0;
          running_value_next = running_value + {1'b0, step_value};
        end else if (hund_done) begin
          mask_next          = BELOW_MASK;
          pos_next           = '0;
          running_value_next = {1'b0, step_value};
        end else begin
          mask_next = hit;
          pos_next  = (pos == 4'hF) ? pos : pos + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask          <= TOP_MASK;
      pos           <= '0;
      running_value <= '0;
      chars_seen    <= '0;
      rejected      <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      mask          <= mask_next;
      pos           <= pos_next;
      running_value <= running_value_next;
      chars_seen    <= chars_seen_next;
      rejected      <= rejected_next;
      if (take_final) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_final) begin
      number_value <= word_ok ? sum[7:0] : 8'd0;
      is_valid     <= word_ok;
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !is_valid) |-> (number_value == 8'd0))
    else $error("invalid result carries a nonzero value");

  a_word_restart: assert property (@(posedge clk) disable iff (rst)
    take_final |=> (mask == TOP_MASK && pos == 4'd0 && running_value == 9'd0
                    && chars_seen == 6'd0 && !rejected))
    else $error("recognizer not back at start of word after last character");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    ((!result_valid || !result_stall) && !take_final) |=> !result_valid)
    else $error("result item appeared without a last character");

  a_hundred_base: assert property (@(posedge clk) disable iff (rst)
    (accept && !final_char && hund_done) |=>
      (running_value == 9'd100 || running_value == 9'd200))
    else $error("hundred prefix gave a wrong base value");

endmodule
